// ===== hw/rtl/rs485gb_pkg.sv =====
// ----------------------------------------------------------------------------
// rs485gb_pkg
// Shared constants, opcodes and inter-module structs for the RS485 idle-gap
// frame buffer.
// ----------------------------------------------------------------------------
package rs485gb_pkg;

    localparam int BUF_DEPTH = 128;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int BUF_CW    = $clog2(BUF_DEPTH + 1);

    localparam logic [7:0] IDLE_TIMEOUT_RST = 8'd50;

    typedef enum logic [2:0] {
        OP_TICK     = 3'd0,
        OP_RX_BYTE  = 3'd1,
        OP_TX_DONE  = 3'd2,
        OP_TX_WRITE = 3'd3,
        OP_TX_START = 3'd4,
        OP_RELEASE  = 3'd5,
        OP_RX_READ  = 3'd6,
        OP_NONE     = 3'd7
    } op_t;

    // one store access request per cycle
    typedef struct packed {
        logic              we;
        logic [BUF_AW-1:0] waddr;
        logic [7:0]        wdata;
        logic              re;
        logic [BUF_AW-1:0] raddr;
    } mem_req_t;

    // status travelling alongside the store read
    typedef struct packed {
        logic       tx_valid;
        logic       rd_valid;
        logic       drive_on;
        logic       frame_done;
        logic [7:0] rx_count;
    } rsp_meta_t;

endpackage

// ===== hw/rtl/rs485gb_ram.sv =====
// ----------------------------------------------------------------------------
// rs485gb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rs485gb_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rs485gb_ctrl.sv =====
// ----------------------------------------------------------------------------
// rs485gb_ctrl
// Receive/transmit control state, idle timer and store address generation.
// ----------------------------------------------------------------------------
module rs485gb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    input  logic                  accept,
    input  logic [2:0]            opcode,
    input  logic [7:0]            data,
    input  logic [6:0]            index,
    input  logic [7:0]            length,
    output rs485gb_pkg::mem_req_t rx_req,
    output rs485gb_pkg::mem_req_t tx_req,
    output rs485gb_pkg::rsp_meta_t meta
);
    import rs485gb_pkg::*;

    logic [7:0]        idle_timeout_reg;
    logic [BUF_CW-1:0] rx_fill_reg,  rx_fill_next;
    logic              frame_done_reg, frame_done_next;
    logic [7:0]        idle_timer_reg, idle_timer_next;
    logic [BUF_CW-1:0] tx_left_reg,  tx_left_next;
    logic [BUF_CW-1:0] tx_pos_reg,   tx_pos_next;
    logic              drive_on_reg, drive_on_next;

    op_t               op;
    logic              idx_ok;
    logic [BUF_AW-1:0] rx_wa;
    logic [BUF_AW-1:0] tx_ra;
    logic [BUF_CW-1:0] len_sat;
    logic [7:0]        timer_dec;
    logic              tx_valid;

    assign op        = op_t'(opcode);
    assign idx_ok    = 32'(index) < 32'(BUF_DEPTH);
    // wrap to 0 when the store is full
    assign rx_wa     = (rx_fill_reg >= BUF_CW'(BUF_DEPTH)) ? '0 : rx_fill_reg[BUF_AW-1:0];
    assign tx_ra     = (tx_pos_reg  >= BUF_CW'(BUF_DEPTH)) ? '0 : tx_pos_reg[BUF_AW-1:0];
    assign len_sat   = (32'(length) > 32'(BUF_DEPTH)) ? BUF_CW'(BUF_DEPTH) : BUF_CW'(length);
    assign timer_dec = idle_timer_reg - 8'd1;

    always_comb begin
        rx_fill_next    = rx_fill_reg;
        frame_done_next = frame_done_reg;
        idle_timer_next = idle_timer_reg;
        tx_left_next    = tx_left_reg;
        tx_pos_next     = tx_pos_reg;
        drive_on_next   = drive_on_reg;
        tx_valid        = 1'b0;
        rx_req          = '0;
        tx_req          = '0;
        rx_req.wdata    = data;
        tx_req.wdata    = data;
        rx_req.waddr    = rx_wa;
        tx_req.waddr    = BUF_AW'(index);
        rx_req.raddr    = BUF_AW'(index);
        tx_req.raddr    = tx_ra;
        if (accept) begin
            unique case (op)
                OP_TICK: begin
                    if (idle_timer_reg != 8'd0) begin
                        idle_timer_next = timer_dec;
                        if (timer_dec == 8'd0 && rx_fill_reg != '0) begin
                            frame_done_next = 1'b1;
                        end
                    end
                end
                OP_RX_BYTE: begin
                    if (!frame_done_reg) begin
                        rx_req.we    = 1'b1;
                        rx_fill_next = BUF_CW'(rx_wa) + BUF_CW'(1);
                    end
                    idle_timer_next = idle_timeout_reg;
                end
                OP_TX_DONE: begin
                    if (tx_left_reg != '0) begin
                        tx_valid     = 1'b1;
                        tx_req.re    = 1'b1;
                        tx_pos_next  = BUF_CW'(tx_ra) + BUF_CW'(1);
                        tx_left_next = tx_left_reg - BUF_CW'(1);
                    end else begin
                        tx_pos_next   = '0;
                        drive_on_next = 1'b0;
                    end
                end
                OP_TX_WRITE: begin
                    tx_req.we = idx_ok;
                end
                OP_TX_START: begin
                    if (length != 8'd0) begin
                        tx_valid      = 1'b1;
                        tx_req.re     = 1'b1;
                        tx_req.raddr  = '0;
                        drive_on_next = 1'b1;
                        tx_pos_next   = BUF_CW'(1);
                        tx_left_next  = len_sat - BUF_CW'(1);
                    end
                end
                OP_RELEASE: begin
                    frame_done_next = 1'b0;
                    rx_fill_next    = '0;
                end
                OP_RX_READ: begin
                    rx_req.re = idx_ok;
                end
                OP_NONE: begin
                end
            endcase
        end
    end

    always_comb begin
        meta.tx_valid   = tx_valid;
        meta.rd_valid   = (op == OP_RX_READ) && idx_ok;
        meta.drive_on   = drive_on_next;
        meta.frame_done = frame_done_next;
        meta.rx_count   = 8'(rx_fill_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idle_timeout_reg <= IDLE_TIMEOUT_RST;
            rx_fill_reg      <= '0;
            frame_done_reg   <= 1'b0;
            idle_timer_reg   <= 8'd0;
            tx_left_reg      <= '0;
            tx_pos_reg       <= '0;
            drive_on_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                idle_timeout_reg <= cfg_data;
            end
            rx_fill_reg    <= rx_fill_next;
            frame_done_reg <= frame_done_next;
            idle_timer_reg <= idle_timer_next;
            tx_left_reg    <= tx_left_next;
            tx_pos_reg     <= tx_pos_next;
            drive_on_reg   <= drive_on_next;
        end
    end

endmodule

// ===== hw/rtl/rs485gb_resp.sv =====
// ----------------------------------------------------------------------------
// rs485gb_resp
// Read-return stage and output register: merges store data with status.
// ----------------------------------------------------------------------------
module rs485gb_resp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   accept,
    input  rs485gb_pkg::rsp_meta_t meta,
    input  logic [7:0]             tx_rdata,
    input  logic [7:0]             rx_rdata,
    output logic                   in_ready,
    input  logic                   m_ready,
    output logic                   m_valid,
    output logic                   m_tx_valid,
    output logic [7:0]             m_tx_byte,
    output logic                   m_driver_enable,
    output logic                   m_frame_ready,
    output logic [7:0]             m_rx_count,
    output logic [7:0]             m_read_data
);
    import rs485gb_pkg::*;

    logic      s1_valid_reg, s1_valid_next;
    rsp_meta_t s1_meta_reg;
    logic      m_valid_reg,  m_valid_next;
    logic      out_free;
    logic      advance;

    logic       tx_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       drive_reg;
    logic       frame_reg;
    logic [7:0] count_reg;
    logic [7:0] rdata_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_meta_reg <= meta;
        end
        if (advance) begin
            tx_valid_reg <= s1_meta_reg.tx_valid;
            tx_byte_reg  <= s1_meta_reg.tx_valid ? tx_rdata : 8'd0;
            drive_reg    <= s1_meta_reg.drive_on;
            frame_reg    <= s1_meta_reg.frame_done;
            count_reg    <= s1_meta_reg.rx_count;
            rdata_reg    <= s1_meta_reg.rd_valid ? rx_rdata : 8'd0;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_tx_valid      = tx_valid_reg;
    assign m_tx_byte       = tx_byte_reg;
    assign m_driver_enable = drive_reg;
    assign m_frame_ready   = frame_reg;
    assign m_rx_count      = count_reg;
    assign m_read_data     = rdata_reg;

endmodule

// ===== hw/rtl/rs485_idle_gap_frame_buffer.sv =====
// ----------------------------------------------------------------------------
// rs485_idle_gap_frame_buffer
// RS485 half-duplex frame buffer with idle-gap end-of-frame detection.
// ----------------------------------------------------------------------------
// Path: a transaction's store read and status are registered on acceptance in
//   the read-return slot, then move into the output register when it is free.
// Throughput: one transaction per cycle while the result channel is not stalled;
//   set by the control update on acceptance and one access per cycle per port.
// Reset: aresetn synchronous, active low; clears all control state and loads
//   the idle timeout with 50. The stores are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module rs485_idle_gap_frame_buffer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: idle timeout in ticks
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data,
    // event / command channel
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_opcode,
    input  logic [7:0] s_data,
    input  logic [6:0] s_index,
    input  logic [7:0] s_length,
    // result channel
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_tx_valid,
    output logic [7:0] m_tx_byte,
    output logic       m_driver_enable,
    output logic       m_frame_ready,
    output logic [7:0] m_rx_count,
    output logic [7:0] m_read_data
);
    import rs485gb_pkg::*;

    logic      accept;
    mem_req_t  rx_req;
    mem_req_t  tx_req;
    rsp_meta_t meta;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;

    // the user must make register writes only while idle; unenforced, always ready
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;

    // Control: updates all scalar state but the idle timeout in the cycle of
    // acceptance and issues the store accesses. A write and a later read of the
    // same entry are always in different cycles, so the stores need no forwarding.
    rs485gb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .accept   (accept),
        .opcode   (s_opcode),
        .data     (s_data),
        .index    (s_index),
        .length   (s_length),
        .rx_req   (rx_req),
        .tx_req   (tx_req),
        .meta     (meta)
    );

    // receive store: written by rx bytes, read back by index
    rs485gb_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8)
    ) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_rdata)
    );

    // transmit store: written by software, read on start and tx done
    rs485gb_ram #(
        .DEPTH (BUF_DEPTH),
        .WIDTH (8)
    ) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_rdata)
    );

    // Read-return slot plus output register: the read data register holds
    // while the slot waits, since no new transaction is taken then.
    rs485gb_resp u_resp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .accept          (accept),
        .meta            (meta),
        .tx_rdata        (tx_rdata),
        .rx_rdata        (rx_rdata),
        .in_ready        (s_ready),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_tx_valid      (m_tx_valid),
        .m_tx_byte       (m_tx_byte),
        .m_driver_enable (m_driver_enable),
        .m_frame_ready   (m_frame_ready),
        .m_rx_count      (m_rx_count),
        .m_read_data     (m_read_data)
    );

`ifndef SYNTHESIS
    // input stalls only when both result slots are full
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled with a free result slot");

    // a byte is only sent while the driver is enabled
    a_tx_needs_driver: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_tx_valid) |-> m_driver_enable)
        else $error("tx byte issued with driver disabled");

    // no stray byte without a send
    a_tx_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tx_valid) |-> (m_tx_byte == 8'd0))
        else $error("tx byte non-zero while not sending");

    // a ready frame always holds bytes
    a_frame_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_frame_ready) |-> (m_rx_count != 8'd0))
        else $error("frame ready with empty receive buffer");
`endif

endmodule
